[hdl/mrcq_pkg.sv]
package mrcq_pkg;

  localparam int unsigned DEPTH  = 16;
  localparam int unsigned PTR_W  = $clog2(DEPTH);
  localparam int unsigned SIZE_W = 5;
  localparam int unsigned CODE_W = 8;
  localparam int unsigned OP_W   = 2;
  localparam int unsigned CFG_W  = 8;
  localparam int unsigned IDX_W  = 1;

  // operation codes
  localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
  localparam logic [OP_W-1:0] OP_GET   = 2'd1;
  localparam logic [OP_W-1:0] OP_PEEK  = 2'd2;

  // configuration register indexes
  localparam logic [IDX_W-1:0] CFG_QUEUE_SIZE   = 1'b0;
  localparam logic [IDX_W-1:0] CFG_EMPTY_MARKER = 1'b1;

  localparam logic [SIZE_W-1:0] QUEUE_SIZE_RST   = 5'd16;
  localparam logic [CODE_W-1:0] EMPTY_MARKER_RST = 8'd0;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [CODE_W-1:0] command_code;
  } req_t;

  typedef struct packed {
    logic [CODE_W-1:0] code_out;
    logic              available;
  } result_t;

  // controller to datapath commands
  typedef struct packed {
    logic load;
    logic exec;
  } dp_cmd_t;

endpackage

[hdl/mrcq_ctrl.sv]
module mrcq_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  output logic             busy_o,
  output logic             done_o,
  output mrcq_pkg::dp_cmd_t cmd_o
);
  import mrcq_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  logic state_q, state_d;
  logic done_q, done_d;

  always_comb begin
    state_d   = state_q;
    done_d    = 1'b0;
    cmd_o     = '0;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd_o.exec = 1'b1;
        done_d     = 1'b1;
        state_d    = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  assign busy_o = (state_q == ST_EXEC);
  assign done_o = done_q;

endmodule

[hdl/mrcq_datapath.sv]
module mrcq_datapath (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  mrcq_pkg::dp_cmd_t              cmd_i,
  input  mrcq_pkg::req_t                 req_i,
  input  logic                           cfg_we_i,
  input  logic [mrcq_pkg::IDX_W-1:0]     cfg_idx_i,
  input  logic [mrcq_pkg::CFG_W-1:0]     cfg_data_i,
  output mrcq_pkg::result_t              result_o
);
  import mrcq_pkg::*;

  req_t              item_q;
  result_t           result_q, result_d;
  logic [CODE_W-1:0] entries_q [DEPTH];
  logic [CODE_W-1:0] entries_d [DEPTH];
  logic [PTR_W-1:0]  rp_q, rp_d;
  logic [SIZE_W-1:0] wp_q, wp_d;
  logic [SIZE_W-1:0] size_q;
  logic [CODE_W-1:0] marker_q;

  logic [SIZE_W-1:0] eff_size;
  logic [SIZE_W-1:0] wp_eff;
  logic [SIZE_W-1:0] rp_inc;
  logic [CODE_W-1:0] rd_code;
  logic              rd_empty;

  always_comb begin
    eff_size = size_q;
    if (size_q == '0) begin
      eff_size = SIZE_W'(1);
    end else if (size_q > SIZE_W'(DEPTH)) begin
      eff_size = SIZE_W'(DEPTH);
    end
  end

  assign wp_eff   = (wp_q >= eff_size) ? '0 : wp_q;
  assign rp_inc   = SIZE_W'(rp_q) + SIZE_W'(1);
  assign rd_code  = entries_q[rp_q];
  assign rd_empty = (rd_code == marker_q);

  always_comb begin
    entries_d = entries_q;
    rp_d      = rp_q;
    wp_d      = wp_q;
    result_d  = result_q;
    if (cmd_i.exec) begin
      result_d = '0;
      case (item_q.op)
        OP_WRITE: begin
          entries_d[wp_eff[PTR_W-1:0]] = item_q.command_code;
          wp_d = wp_eff + SIZE_W'(1);
        end
        OP_GET, OP_PEEK: begin
          if (rd_empty) begin
            result_d.code_out = marker_q;
          end else begin
            result_d.code_out  = rd_code;
            result_d.available = 1'b1;
            if (item_q.op == OP_GET) begin
              entries_d[rp_q] = marker_q;
              rp_d = (rp_inc >= eff_size) ? '0 : rp_inc[PTR_W-1:0];
            end
          end
        end
        default: begin
          result_d = '0;
        end
      endcase
    end
  end

  // item and result payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      item_q <= req_i;
    end
    result_q <= result_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < DEPTH; i++) begin
        entries_q[i] <= EMPTY_MARKER_RST;
      end
      rp_q     <= '0;
      wp_q     <= '0;
      size_q   <= QUEUE_SIZE_RST;
      marker_q <= EMPTY_MARKER_RST;
    end else begin
      entries_q <= entries_d;
      rp_q      <= rp_d;
      wp_q      <= wp_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_QUEUE_SIZE:   size_q   <= cfg_data_i[SIZE_W-1:0];
          CFG_EMPTY_MARKER: marker_q <= cfg_data_i[CODE_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  assign result_o = result_q;

endmodule

[hdl/marker_ring_command_queue.sv]
// marker ring command queue: one request at a time through a two-state controller
// an accepted request is loaded into the item register and executed, then its result and done_o are registered together
// a new request is taken only once the controller is back in idle; busy_o is high for the execute cycle only
// the receiver cannot stall: each result is strobed on done_o for exactly one cycle
// reset (rst_ni low, async): all 16 entries read as the empty marker, both positions 0,
// queue size 16, empty marker 0
module marker_ring_command_queue (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // request channel
  input  logic                           start_i,
  output logic                           busy_o,
  input  mrcq_pkg::req_t                 req_i,
  // result channel
  output logic                           done_o,
  output mrcq_pkg::result_t              result_o,
  // configuration write port
  input  logic                           cfg_we_i,
  input  logic [mrcq_pkg::IDX_W-1:0]     cfg_idx_i,
  input  logic [mrcq_pkg::CFG_W-1:0]     cfg_data_i
);
  import mrcq_pkg::*;

  dp_cmd_t dp_cmd;
  logic    req_accept;

  // request taken only when the controller is idle
  assign req_accept = start_i && !busy_o;

  // controller: idle -> execute -> idle, strobes done after execute
  mrcq_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .busy_o (busy_o),
    .done_o (done_o),
    .cmd_o  (dp_cmd)
  );

  // datapath: entry registers, read/write positions, config, result register
  mrcq_datapath u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (dp_cmd),
    .req_i     (req_i),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .result_o  (result_o)
  );

  // an accepted request moves the controller into execute
  assert property (@(posedge clk_i) disable iff (!rst_ni) req_accept |=> busy_o)
    else $error("accepted request did not start execution");

  // execute is always followed by a result strobe, with busy_o low again
  assert property (@(posedge clk_i) disable iff (!rst_ni) busy_o |=> (done_o && !busy_o))
    else $error("execute cycle not followed by result");

  // a result strobe only follows an execute cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni) done_o |-> $past(busy_o))
    else $error("result strobe without execution");

endmodule

[tb/sv/tb.sv]
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mrcq_pkg::*;

  // op value that the block treats as a no-op
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  // dut inputs, all known from time zero
  logic              clk_i      = 1'b0;
  logic              rst_ni     = 1'b0;
  logic              start_i    = 1'b0;
  req_t              req_i      = '0;
  logic              cfg_we_i   = 1'b0;
  logic [IDX_W-1:0]  cfg_idx_i  = '0;
  logic [CFG_W-1:0]  cfg_data_i = '0;
  logic              busy_o;
  logic              done_o;
  result_t           result_o;

  // shadow copy of the ring, its two positions and both registers
  logic [CODE_W-1:0] ring_codes [DEPTH];
  int unsigned       rd_ptr;
  int unsigned       wr_ptr;
  logic [SIZE_W-1:0] size_reg;
  logic [CODE_W-1:0] marker_reg;

  // codes still owed by the block, oldest first
  result_t           pending_codes [$];
  int unsigned       mismatch_count = 0;

  // 12 ns clock
  always #6 clk_i = ~clk_i;

  marker_ring_command_queue u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .busy_o     (busy_o),
    .req_i      (req_i),
    .done_o     (done_o),
    .result_o   (result_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  // advance the shadow ring by one request and return the code it should report
  function automatic result_t predict_code(req_t r);
    result_t           res;
    int unsigned       used;
    int unsigned       nxt;
    logic [CODE_W-1:0] found;
    res = '0;
    // size zero acts as one, anything past the ring saturates
    used = size_reg;
    if (used == 0) used = 1;
    if (used > DEPTH) used = DEPTH;
    if (r.op == OP_WRITE) begin
      // no full check: wrap first, then overwrite whatever sits there
      if (wr_ptr >= used) wr_ptr = 0;
      ring_codes[wr_ptr] = r.command_code;
      wr_ptr = wr_ptr + 1;
    end else if (r.op == OP_GET || r.op == OP_PEEK) begin
      found = ring_codes[rd_ptr];
      if (found == marker_reg) begin
        // only the current marker counts as empty
        res.code_out = marker_reg;
      end else begin
        res.code_out  = found;
        res.available = 1'b1;
        if (r.op == OP_GET) begin
          // read position may sit past a shrunken size, then it wraps to 0
          nxt = rd_ptr + 1;
          if (nxt >= used) nxt = 0;
          ring_codes[rd_ptr] = marker_reg;
          rd_ptr = nxt;
        end
      end
    end
    return res;
  endfunction

  // one process owns the shadow state: check the strobed result first, then
  // take in register writes and newly accepted requests seen at this edge
  always @(posedge clk_i or negedge rst_ni) begin
    result_t want;
    if (!rst_ni) begin
      for (int i = 0; i < DEPTH; i++) ring_codes[i] = EMPTY_MARKER_RST;
      rd_ptr     = 0;
      wr_ptr     = 0;
      size_reg   = QUEUE_SIZE_RST;
      marker_reg = EMPTY_MARKER_RST;
      pending_codes.delete();
    end else begin
      if ($isunknown({done_o, busy_o})) begin
        mismatch_count++;
        $display("%0t: handshake unknown, expected known, actual done=%b busy=%b",
                 $time, done_o, busy_o);
      end else if (done_o) begin
        if (pending_codes.size() == 0) begin
          mismatch_count++;
          $display("%0t: stray result, expected none, actual code=%h avail=%b",
                   $time, result_o.code_out, result_o.available);
        end else begin
          want = pending_codes.pop_front();
          if (result_o.code_out !== want.code_out) begin
            mismatch_count++;
            $display("%0t: code_out mismatch, expected %h, actual %h",
                     $time, want.code_out, result_o.code_out);
          end
          if (result_o.available !== want.available) begin
            mismatch_count++;
            $display("%0t: available mismatch, expected %b, actual %b",
                     $time, want.available, result_o.available);
          end
        end
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_QUEUE_SIZE:   size_reg   = cfg_data_i[SIZE_W-1:0];
          CFG_EMPTY_MARKER: marker_reg = cfg_data_i[CODE_W-1:0];
          default: ;
        endcase
      end
      if (start_i && !busy_o) pending_codes.push_back(predict_code(req_i));
    end
  end

  // hold a request until the block takes it; start stays high for a follow-on
  task automatic send_request(logic [OP_W-1:0] op, logic [CODE_W-1:0] code);
    start_i <= 1'b1;
    req_i   <= req_t'{op: op, command_code: code};
    do @(posedge clk_i); while (busy_o !== 1'b0);
  endtask

  task automatic idle_cycles(int unsigned n);
    start_i <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  // stop sending and let every owed result come back
  task automatic wait_drained();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (pending_codes.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  // registers change only with the block idle
  task automatic write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    wait_drained();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    @(posedge clk_i);
  endtask

  // reads on an empty ring, the no-op, and storing the marker value itself
  task automatic test_empty_reads();
    send_request(OP_PEEK, 8'h00);
    send_request(OP_GET, 8'hFF);
    send_request(OP_UNUSED, 8'hFF);
    send_request(OP_WRITE, 8'hFF);
    send_request(OP_WRITE, 8'h00);
    send_request(OP_WRITE, 8'hA5);
    send_request(OP_GET, 8'h00);
    // entry holds the marker: get is stuck, peek agrees
    send_request(OP_GET, 8'h00);
    send_request(OP_PEEK, 8'h00);
  endtask

  // marker moved after use: old zero entries now read as real codes
  task automatic test_marker_change();
    write_reg(CFG_EMPTY_MARKER, 8'hFF);
    send_request(OP_GET, 8'h00);
    send_request(OP_GET, 8'h00);
    send_request(OP_GET, 8'h00);
    send_request(OP_WRITE, 8'hFF);
    send_request(OP_PEEK, 8'h00);
  endtask

  // smallest size, size zero and size past the ring
  task automatic test_size_extremes();
    write_reg(CFG_QUEUE_SIZE, 8'd1);
    // write position past the size wraps, read position past it wraps on advance
    send_request(OP_WRITE, 8'h11);
    send_request(OP_GET, 8'h00);
    send_request(OP_GET, 8'h00);
    send_request(OP_WRITE, 8'h22);
    send_request(OP_WRITE, 8'h33);
    send_request(OP_GET, 8'h00);
    write_reg(CFG_QUEUE_SIZE, 8'd0);
    send_request(OP_WRITE, 8'h44);
    send_request(OP_GET, 8'h00);
    // upper data bits dropped, 31 saturates to the ring depth
    write_reg(CFG_QUEUE_SIZE, 8'hFF);
    send_request(OP_WRITE, 8'h55);
    send_request(OP_WRITE, 8'h66);
    send_request(OP_GET, 8'h00);
  endtask

  // sender stops until nothing is owed, then picks up again
  task automatic test_drained_restart();
    write_reg(CFG_EMPTY_MARKER, 8'h00);
    for (int i = 0; i < 3; i++) send_request(OP_WRITE, 8'($urandom_range(1, 255)));
    wait_drained();
    for (int i = 0; i < 3; i++) send_request(OP_GET, 8'($urandom_range(0, 255)));
    send_request(OP_PEEK, 8'h00);
  endtask

  // mixed traffic; the write share drifts so the ring both fills and drains
  task automatic test_random_traffic(int unsigned n_items, int unsigned gap_pct);
    int unsigned       fill_pct;
    int unsigned       pick;
    logic [CODE_W-1:0] code;
    fill_pct = 50;
    for (int unsigned k = 0; k < n_items; k++) begin
      if (k % 24 == 0) fill_pct = $urandom_range(15, 85);
      // some writes store the marker on purpose
      code = ($urandom_range(0, 7) == 0) ? marker_reg : 8'($urandom_range(0, 255));
      pick = $urandom_range(0, 99);
      if (pick < fill_pct) begin
        send_request(OP_WRITE, code);
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 60) send_request(OP_GET, code);
        else if (pick < 93) send_request(OP_PEEK, code);
        else send_request(OP_UNUSED, code);
      end
      if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct)
        idle_cycles($urandom_range(1, 16));
    end
  endtask

  // one phase per register setting, extremes first, gaps off at the end
  task automatic test_config_sweep();
    logic [CFG_W-1:0] size_val;
    logic [CFG_W-1:0] mark_val;
    for (int p = 0; p < 9; p++) begin
      case (p)
        0:       begin size_val = 8'd16;  mark_val = 8'h00; end
        1:       begin size_val = 8'd1;   mark_val = 8'hFF; end
        2:       begin size_val = 8'd2;   mark_val = 8'($urandom_range(0, 255)); end
        3:       begin size_val = 8'd0;   mark_val = 8'h00; end
        4:       begin size_val = 8'hFF;  mark_val = 8'hFF; end
        default: begin
          size_val = 8'($urandom_range(0, 255));
          mark_val = 8'($urandom_range(0, 255));
        end
      endcase
      write_reg(CFG_QUEUE_SIZE, size_val);
      write_reg(CFG_EMPTY_MARKER, mark_val);
      test_random_traffic(148, (p == 8) ? 0 : ((p % 3 == 1) ? 5 : 20));
    end
  endtask

  initial begin
    // single reset at the start
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_empty_reads();
    test_marker_change();
    test_size_extremes();
    test_drained_restart();
    test_config_sweep();
    wait_drained();
    repeat (8) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #5000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

[files.f]
hdl/mrcq_pkg.sv
hdl/mrcq_ctrl.sv
hdl/mrcq_datapath.sv
hdl/marker_ring_command_queue.sv
tb/sv/tb.sv
